### sv/lsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lsd_pkg;

    localparam int WINDOW_BYTES = 4096;
    localparam int AW           = $clog2(WINDOW_BYTES);
    localparam int FW           = AW + 1;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPW          = $clog2(QUEUE_DEPTH);
    localparam int QCW          = $clog2(QUEUE_DEPTH + 1);

    localparam logic [AW-1:0] START_POS  = AW'(WINDOW_BYTES - 16);
    localparam logic [7:0]    SPACE_BYTE = 8'h20;
    localparam logic [15:0]   MAX_RESET  = 16'hFFFF;
    localparam logic [4:0]    LEN_EXTRA  = 5'd2;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_LIT,
        CMD_MATCH
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind     kind;
        logic [7:0]    data;
        logic [AW-1:0] src;
        logic [3:0]    len_m3;
        logic          last;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LIT,
        ST_READ,
        ST_DATA
    } t_back_state;

endpackage
`default_nettype wire

### sv/lsd_front.sv
`timescale 1ns / 1ps
`default_nettype none
module lsd_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [7:0]    i_in_byte,
    input  wire logic          i_last_byte,
    input  wire logic          i_q_full,
    input  wire logic          i_hold,
    output logic               o_stall,
    output logic               o_push,
    output lsd_pkg::t_cmd      o_cmd
);
    import lsd_pkg::*;

    logic [7:0] r_flag_bits, n_flag_bits;
    logic [3:0] r_flags_left, n_flags_left;
    logic       r_phase, n_phase;
    logic [7:0] r_offset_low, n_offset_low;
    logic       accept;

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;

    always_comb begin
        n_flag_bits  = r_flag_bits;
        n_flags_left = r_flags_left;
        n_phase      = r_phase;
        n_offset_low = r_offset_low;
        o_cmd.kind   = CMD_NONE;
        o_cmd.data   = i_in_byte;
        o_cmd.src    = {i_in_byte[7:4], r_offset_low};
        o_cmd.len_m3 = i_in_byte[3:0];
        o_cmd.last   = i_last_byte;
        // output budget spent: ignore the byte and hold the parser
        if (accept && !i_hold) begin
            if (r_flags_left == 4'd0) begin
                n_flag_bits  = i_in_byte;
                n_flags_left = 4'd8;
                n_phase      = 1'b0;
            end else if (!r_phase) begin
                if (r_flag_bits[0]) begin
                    o_cmd.kind   = CMD_LIT;
                    n_flag_bits  = {1'b0, r_flag_bits[7:1]};
                    n_flags_left = r_flags_left - 4'd1;
                end else begin
                    n_offset_low = i_in_byte;
                    n_phase      = 1'b1;
                end
            end else begin
                o_cmd.kind   = CMD_MATCH;
                n_flag_bits  = {1'b0, r_flag_bits[7:1]};
                n_flags_left = r_flags_left - 4'd1;
                n_phase      = 1'b0;
            end
        end
        // end of stream: drop any partial token
        if (accept && i_last_byte) begin
            n_flag_bits  = 8'd0;
            n_flags_left = 4'd0;
            n_phase      = 1'b0;
            n_offset_low = 8'd0;
        end
    end

    assign o_push = accept && ((o_cmd.kind != CMD_NONE) || i_last_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag_bits  <= 8'd0;
            r_flags_left <= 4'd0;
            r_phase      <= 1'b0;
            r_offset_low <= 8'd0;
        end else begin
            r_flag_bits  <= n_flag_bits;
            r_flags_left <= n_flags_left;
            r_phase      <= n_phase;
            r_offset_low <= n_offset_low;
        end
    end

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_q_full)
        else $error("front pushed into a full queue");
    a_flags_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flags_left <= 4'd8)
        else $error("flag counter out of range");

endmodule
`default_nettype wire

### sv/lsd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module lsd_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire lsd_pkg::t_cmd i_cmd,
    input  wire logic          i_pop,
    output lsd_pkg::t_cmd      o_cmd,
    output logic               o_valid,
    output logic               o_full
);
    import lsd_pkg::*;

    t_cmd           r_mem [QUEUE_DEPTH];
    logic [QPW-1:0] r_wr, r_rd;
    logic [QCW-1:0] r_count;

    assign o_valid = (r_count != QCW'(0));
    assign o_full  = (r_count == QCW'(QUEUE_DEPTH));
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == QPW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + QPW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == QPW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + QPW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCW'(1);
                2'b01:   r_count <= r_count - QCW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from an empty queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCW'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule
`default_nettype wire

### sv/lsd_back.sv
`timescale 1ns / 1ps
`default_nettype none
module lsd_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    input  wire lsd_pkg::t_cmd i_cmd,
    output logic               o_pop,
    input  wire logic [15:0]   i_max_bytes,
    output logic               o_hold,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic [7:0]         o_out_byte,
    output logic               o_run_end,
    output logic               o_limit_reached
);
    import lsd_pkg::*;

    t_back_state   r_state, n_state;
    logic          r_cmd_last;
    logic [7:0]    r_data;
    logic [AW-1:0] r_src;
    logic [4:0]    r_left;
    logic [AW-1:0] r_wp;
    logic [FW-1:0] r_fill;
    logic [15:0]   r_bytes_out;
    logic          r_halted;
    logic [7:0]    r_rd_q;
    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic          r_run_end;
    logic          r_limit;
    logic [7:0]    r_win [WINDOW_BYTES];

    logic          active, slot_free, win_ok, match_end;
    logic [15:0]   bytes_next;
    logic [AW-1:0] rel;
    logic [7:0]    rd_byte;
    logic          start, emit, emit_end, reinit;
    logic [7:0]    emit_byte;

    assign active     = !r_halted && (r_bytes_out < i_max_bytes);
    assign slot_free  = !r_out_valid || !i_stall;
    assign bytes_next = r_bytes_out + 16'd1;
    // entries not yet written since the stream began still read as spaces
    assign rel        = r_src - START_POS;
    assign win_ok     = r_fill[AW] || (rel < r_fill[AW-1:0]);
    assign rd_byte    = win_ok ? r_rd_q : SPACE_BYTE;
    assign match_end  = (r_left == 5'd0) || (bytes_next >= i_max_bytes);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid && active) begin
                    if (i_cmd.kind == CMD_LIT) begin
                        n_state = ST_LIT;
                    end else if (i_cmd.kind == CMD_MATCH) begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_LIT: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_READ: n_state = ST_DATA;
            ST_DATA: begin
                if (slot_free) begin
                    n_state = match_end ? ST_IDLE : ST_READ;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop     = (r_state == ST_IDLE) && i_q_valid;
        start     = o_pop && active && (i_cmd.kind != CMD_NONE);
        emit      = slot_free && ((r_state == ST_LIT) || (r_state == ST_DATA));
        emit_byte = (r_state == ST_LIT) ? r_data : rd_byte;
        emit_end  = (r_state == ST_LIT) ? 1'b1 : match_end;
        reinit    = (o_pop && !start && i_cmd.last) || (emit && emit_end && r_cmd_last);
    end

    // limit at or below the count without a halt: the parser must not advance;
    // at the end of a stream the fresh stream is held only by a zero limit
    assign o_hold = reinit ? (i_max_bytes == 16'd0)
                           : (!r_halted && (r_bytes_out >= i_max_bytes));

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_win[r_wp] <= emit_byte;
        end
        if (r_state == ST_READ) begin
            r_rd_q <= r_win[r_src];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd_last <= i_cmd.last;
            r_data     <= i_cmd.data;
            r_src      <= i_cmd.src;
            r_left     <= {1'b0, i_cmd.len_m3} + LEN_EXTRA;
        end else if (emit && (r_state == ST_DATA)) begin
            r_src  <= r_src + AW'(1);
            r_left <= r_left - 5'd1;
        end
        if (emit) begin
            r_out_byte <= emit_byte;
            r_run_end  <= emit_end;
            r_limit    <= (bytes_next == i_max_bytes);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_wp        <= START_POS;
            r_fill      <= '0;
            r_bytes_out <= 16'd0;
            r_halted    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (reinit) begin
                r_wp        <= START_POS;
                r_fill      <= '0;
                r_bytes_out <= 16'd0;
                r_halted    <= 1'b0;
            end else if (emit) begin
                r_wp        <= r_wp + AW'(1);
                r_fill      <= r_fill[AW] ? r_fill : r_fill + FW'(1);
                r_bytes_out <= bytes_next;
                if (bytes_next >= i_max_bytes) begin
                    r_halted <= 1'b1;
                end
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_out_byte      = r_out_byte;
    assign o_run_end       = r_run_end;
    assign o_limit_reached = r_limit;

    a_emit_in_budget: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> (!r_halted && (r_bytes_out < i_max_bytes)))
        else $error("byte produced beyond the output limit");
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(WINDOW_BYTES))
        else $error("fill count beyond window size");
    a_reinit_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        reinit |=> ((r_wp == START_POS) && (r_fill == '0) && (r_bytes_out == 16'd0)))
        else $error("stream state not restored at end of stream");

endmodule
`default_nettype wire

### sv/lzss_stream_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// LZSS decompressor with a 4096-byte window.
// Input channel (i_valid / o_stall): one compressed byte per item, with
// i_last_byte marking the final byte of a stream. Output channel
// (o_valid / i_stall): one decompressed byte per item, with o_run_end on the
// last byte caused by an input item and o_limit_reached on the byte that
// fills the configured limit. Config channel (i_cfg_valid / o_cfg_ready,
// always ready) writes max_output_bytes; write it only while idle.
// The front parser takes one input item per cycle while its two-entry
// command queue has room; flag bytes and match low bytes produce nothing.
// Back end: a new command is taken from the queue only when idle; a
// literal is written to the window and the output register, and each
// byte of a match is a window read (ST_READ) then a write and output
// (ST_DATA). When the receiver stalls, the output register holds, the
// back end waits, the queue fills and o_stall rises.
// Reset (and the end of every stream) returns write position to 4080 and
// the fill count to zero; unwritten window bytes read as spaces through the
// fill count, so no clearing pass is needed. Reset sets the limit to 65535.
module lzss_stream_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_last_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_out_byte,
    output logic             o_run_end,
    output logic             o_limit_reached,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data
);
    import lsd_pkg::*;

    logic [15:0] r_max_bytes;
    logic        push, pop, q_full, q_valid, hold;
    t_cmd        front_cmd, q_cmd;

    // config register: always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_bytes <= MAX_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_bytes <= i_cfg_data;
        end
    end

    // parse flag bits and tokens into commands; hold the parser while a
    // lowered limit leaves no budget, so later bytes are simply dropped
    lsd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_in_byte   (i_in_byte),
        .i_last_byte (i_last_byte),
        .i_q_full    (q_full),
        .i_hold      (hold),
        .o_stall     (o_stall),
        .o_push      (push),
        .o_cmd       (front_cmd)
    );

    // decouple parsing from copying
    lsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (q_cmd),
        .o_valid (q_valid),
        .o_full  (q_full)
    );

    // execute literals and matches against the window
    lsd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_cmd           (q_cmd),
        .o_pop           (pop),
        .i_max_bytes     (r_max_bytes),
        .o_hold          (hold),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_byte      (o_out_byte),
        .o_run_end       (o_run_end),
        .o_limit_reached (o_limit_reached)
    );

endmodule
`default_nettype wire
